FILE: design/tep_pkg.sv
// ----------------------------------------------------------------------------
// tep_pkg
// Shared types, constants and beat field offsets of the tree ensemble predictor.
// ----------------------------------------------------------------------------
package tep_pkg;

    localparam int TREES_DEF    = 64;
    localparam int NODES_DEF    = 256;
    localparam int FEATURES_DEF = 32;

    localparam logic [1:0] ACT_NODE_WR = 2'd0;
    localparam logic [1:0] ACT_FEAT_WR = 2'd1;
    localparam logic [1:0] ACT_PREDICT = 2'd2;

    localparam int IN_USER_W  = 2;
    localparam int IN_DATA_W  = 144;
    localparam int OUT_USER_W = 1;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_W      = 7;

    localparam int OFS_TREE      = 0;
    localparam int OFS_NODE      = 6;
    localparam int OFS_SPLIT_FT  = 14;
    localparam int OFS_SPLIT_VAL = 20;
    localparam int OFS_LEFT      = 52;
    localparam int OFS_RIGHT     = 60;
    localparam int OFS_LEAF      = 68;
    localparam int OFS_FEAT_IDX  = 100;
    localparam int OFS_FEAT_VAL  = 105;

    typedef struct packed {
        logic [5:0]  split_feature;
        logic [31:0] split_value;
        logic [7:0]  left_child;
        logic [7:0]  right_child;
        logic [31:0] leaf_value;
    } t_node;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_NODE_RD   = 6'b000010,
        ST_NODE_EVAL = 6'b000100,
        ST_FEAT_EVAL = 6'b001000,
        ST_DIV       = 6'b010000,
        ST_DONE      = 6'b100000
    } t_state;

endpackage

FILE: design/tree_ensemble_predict.sv
// ----------------------------------------------------------------------------
// tree_ensemble_predict
// Random forest regression inference over node tables held in block RAM.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat content
//  s_axis    in         tuser: action; tdata: node entry, feature slot and value
//  m_axis    out        tuser: depth_error; tdata: prediction
//  cfg       in         data: tree_count
//
//  A node or feature write produces no output beat.
//  A prediction walks each tree through the single read port of the node memory,
//  reading the node and, for a split node, its feature, then divides the sum by
//  the tree count in a bit-serial divider and applies the sign fix.
//  The input side is held off from a prediction beat until its result is loaded
//  into the output register; a stalled output holds the last cycle of a prediction.
//  Reset is synchronous and clears control state only; memories are not cleared.
// ----------------------------------------------------------------------------
module tree_ensemble_predict #(
    parameter int TREES    = tep_pkg::TREES_DEF,
    parameter int NODES    = tep_pkg::NODES_DEF,
    parameter int FEATURES = tep_pkg::FEATURES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // tree_index, node_index, split_feature, split_value, left_child,
    // right_child, leaf_value, feature_index, feature_value, zero pad
    input  logic [tep_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // action
    input  logic [tep_pkg::IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // prediction
    output logic [tep_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // depth_error
    output logic [tep_pkg::OUT_USER_W-1:0] o_m_axis_tuser,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tep_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int DEPTH = TREES * NODES;
    localparam int AW    = $clog2(DEPTH);
    localparam int FAW   = FEATURES > 1 ? $clog2(FEATURES) : 1;
    localparam int CW    = $clog2(TREES + 1);
    localparam int MW    = $clog2(NODES + 1);
    localparam int SW    = 33 + $clog2(TREES);
    localparam int BW    = $clog2(SW);

    tep_pkg::t_state r_state, n_state;

    logic [6:0]           r_tree_count;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_tree, n_tree;
    logic [AW-1:0]        r_base, n_base;
    logic [7:0]           r_node, n_node;
    logic [MW-1:0]        r_moves, n_moves;
    logic signed [SW-1:0] r_sum, n_sum;
    logic                 r_err, n_err;
    logic [SW-1:0]        r_quo, n_quo;
    logic [CW-1:0]        r_rem, n_rem;
    logic [BW-1:0]        r_bit, n_bit;
    logic                 r_neg, n_neg;
    logic                 r_out_valid, n_out_valid;
    logic [31:0]          r_out_data, n_out_data;
    logic                 r_out_err, n_out_err;

    logic [1:0]    w_action;
    logic [5:0]    w_tree_index;
    logic [7:0]    w_node_index;
    logic [4:0]    w_feat_index;
    tep_pkg::t_node w_node_wr;
    logic [31:0]   w_feat_value;
    logic          w_in_beat;
    logic          w_node_we;
    logic          w_feat_we;
    logic [AW-1:0] w_node_waddr;
    logic          w_node_re;
    logic [AW-1:0] w_node_raddr;
    logic          w_feat_re;
    logic [FAW-1:0] w_feat_raddr;
    tep_pkg::t_node w_node_rd;
    logic [31:0]   w_feat_rd;
    logic signed [31:0] w_x;
    logic [7:0]    w_next;
    logic          w_tree_end;
    logic          w_tree_last;
    logic [CW:0]   w_rem_sh;
    logic [31:0]   w_q;

    assign w_action      = i_s_axis_tuser[1:0];
    assign w_tree_index  = i_s_axis_tdata[tep_pkg::OFS_TREE +: 6];
    assign w_node_index  = i_s_axis_tdata[tep_pkg::OFS_NODE +: 8];
    assign w_feat_index  = i_s_axis_tdata[tep_pkg::OFS_FEAT_IDX +: 5];
    assign w_feat_value  = i_s_axis_tdata[tep_pkg::OFS_FEAT_VAL +: 32];
    assign w_node_wr.split_feature = i_s_axis_tdata[tep_pkg::OFS_SPLIT_FT +: 6];
    assign w_node_wr.split_value   = i_s_axis_tdata[tep_pkg::OFS_SPLIT_VAL +: 32];
    assign w_node_wr.left_child    = i_s_axis_tdata[tep_pkg::OFS_LEFT +: 8];
    assign w_node_wr.right_child   = i_s_axis_tdata[tep_pkg::OFS_RIGHT +: 8];
    assign w_node_wr.leaf_value    = i_s_axis_tdata[tep_pkg::OFS_LEAF +: 32];

    assign o_s_axis_tready = (r_state == tep_pkg::ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign w_in_beat       = i_s_axis_tvalid && o_s_axis_tready;

    assign w_node_we = w_in_beat && (w_action == tep_pkg::ACT_NODE_WR)
                       && (32'(w_tree_index) < TREES) && (32'(w_node_index) < NODES);
    assign w_feat_we = w_in_beat && (w_action == tep_pkg::ACT_FEAT_WR)
                       && (32'(w_feat_index) < FEATURES);
    assign w_node_waddr = AW'(32'(w_tree_index) * NODES + 32'(w_node_index));

    assign w_node_re    = (r_state == tep_pkg::ST_NODE_RD);
    assign w_node_raddr = r_base + AW'(r_node);
    assign w_feat_re    = (r_state == tep_pkg::ST_NODE_EVAL);
    assign w_feat_raddr = FAW'(w_node_rd.split_feature - 6'd1);

    tep_ram #(
        .WIDTH ($bits(tep_pkg::t_node)),
        .DEPTH (DEPTH)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (w_node_we),
        .i_waddr (w_node_waddr),
        .i_wdata (w_node_wr),
        .i_re    (w_node_re),
        .i_raddr (w_node_raddr),
        .o_rdata (w_node_rd)
    );

    tep_ram #(
        .WIDTH (32),
        .DEPTH (FEATURES)
    ) u_feat_ram (
        .i_clk   (i_clk),
        .i_we    (w_feat_we),
        .i_waddr (FAW'(w_feat_index)),
        .i_wdata (w_feat_value),
        .i_re    (w_feat_re),
        .i_raddr (w_feat_raddr),
        .o_rdata (w_feat_rd)
    );

    assign w_x = (32'(w_node_rd.split_feature) <= FEATURES) ? $signed(w_feat_rd) : 32'sd0;
    assign w_next = (w_x <= $signed(w_node_rd.split_value)) ? w_node_rd.left_child
                                                            : w_node_rd.right_child;
    assign w_tree_last = (r_tree + CW'(1)) == r_count;
    assign w_rem_sh    = {r_rem, r_quo[SW-1]};
    assign w_q         = r_quo[31:0];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_tree      = r_tree;
        n_base      = r_base;
        n_node      = r_node;
        n_moves     = r_moves;
        n_sum       = r_sum;
        n_err       = r_err;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        n_out_err   = r_out_err;
        w_tree_end  = 1'b0;

        unique case (r_state)
            tep_pkg::ST_IDLE: begin
                if (w_in_beat && (w_action == tep_pkg::ACT_PREDICT)) begin
                    if (r_tree_count == 7'd0) begin
                        n_count = CW'(1);
                    end else if (32'(r_tree_count) > TREES) begin
                        n_count = CW'(TREES);
                    end else begin
                        n_count = CW'(r_tree_count);
                    end
                    n_tree  = '0;
                    n_base  = '0;
                    n_node  = '0;
                    n_moves = '0;
                    n_sum   = '0;
                    n_err   = 1'b0;
                    n_state = tep_pkg::ST_NODE_RD;
                end
            end
            tep_pkg::ST_NODE_RD: begin
                n_state = tep_pkg::ST_NODE_EVAL;
            end
            tep_pkg::ST_NODE_EVAL: begin
                if (w_node_rd.split_feature == 6'd0) begin
                    n_sum      = r_sum + SW'($signed(w_node_rd.leaf_value));
                    w_tree_end = 1'b1;
                end else if (32'(r_moves) >= NODES) begin
                    n_err      = 1'b1;
                    w_tree_end = 1'b1;
                end else begin
                    n_state = tep_pkg::ST_FEAT_EVAL;
                end
            end
            tep_pkg::ST_FEAT_EVAL: begin
                if (32'(w_next) >= NODES) begin
                    n_err      = 1'b1;
                    w_tree_end = 1'b1;
                end else begin
                    n_node  = w_next;
                    n_moves = r_moves + MW'(1);
                    n_state = tep_pkg::ST_NODE_RD;
                end
            end
            tep_pkg::ST_DIV: begin
                if (w_rem_sh >= {1'b0, r_count}) begin
                    n_rem = CW'(w_rem_sh - {1'b0, r_count});
                    n_quo = {r_quo[SW-2:0], 1'b1};
                end else begin
                    n_rem = w_rem_sh[CW-1:0];
                    n_quo = {r_quo[SW-2:0], 1'b0};
                end
                n_bit = r_bit + BW'(1);
                if (r_bit == BW'(SW - 1)) begin
                    n_state = tep_pkg::ST_DONE;
                end
            end
            tep_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_neg ? (32'd0 - w_q) : w_q;
                    n_out_err   = r_err;
                    n_state     = tep_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tep_pkg::ST_IDLE;
            end
        endcase

        if (w_tree_end) begin
            if (w_tree_last) begin
                n_neg   = n_sum[SW-1];
                n_quo   = n_sum[SW-1] ? (SW'(0) - SW'(n_sum)) : SW'(n_sum);
                n_rem   = '0;
                n_bit   = '0;
                n_state = tep_pkg::ST_DIV;
            end else begin
                n_tree  = r_tree + CW'(1);
                n_base  = r_base + AW'(NODES);
                n_node  = '0;
                n_moves = '0;
                n_state = tep_pkg::ST_NODE_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tep_pkg::ST_IDLE;
            r_tree_count <= 7'd1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tree_count <= i_cfg_data[6:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_count    <= n_count;
        r_tree     <= n_tree;
        r_base     <= n_base;
        r_node     <= n_node;
        r_moves    <= n_moves;
        r_sum      <= n_sum;
        r_err      <= n_err;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_bit      <= n_bit;
        r_neg      <= n_neg;
        r_out_data <= n_out_data;
        r_out_err  <= n_out_err;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_err;

endmodule

FILE: design/tep_ram.sv
// ----------------------------------------------------------------------------
// tep_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module tep_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/tep_checker.sv
// ----------------------------------------------------------------------------
// tep_checker
// Port-level checks of the tree ensemble predictor, bound to its top level.
// ----------------------------------------------------------------------------
module tep_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic [tep_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    input logic [tep_pkg::IN_USER_W-1:0]  i_s_axis_tuser,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [tep_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [tep_pkg::OUT_USER_W-1:0] o_m_axis_tuser,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [tep_pkg::CFG_W-1:0]      i_cfg_data
);

    logic w_in_beat;
    logic w_predict;

    assign w_in_beat = i_s_axis_tvalid && o_s_axis_tready;
    assign w_predict = i_s_axis_tuser[1:0] == tep_pkg::ACT_PREDICT;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && $past(o_m_axis_tvalid && !i_m_axis_tready && i_rst_n)
        |-> $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("Output beat changed while stalled.");

    a_predict_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && w_predict |=> !o_s_axis_tready)
        else $error("Input accepted again right after a prediction beat.");

    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && !w_predict |=> o_s_axis_tready)
        else $error("Input stalled after a write beat.");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) && $past(i_rst_n) |-> $past(!o_s_axis_tready))
        else $error("Output beat appeared without a prediction in flight.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("Output valid after reset.");

endmodule

bind tree_ensemble_predict tep_checker u_tep_checker (.*);
